FILE: hdl/dqd_pkg.sv
// ----------------------------------------------------------------------------
// dqd_pkg: shared types and codes for the bounded deque
// Request and result payloads, operation and status codes, cell commands
// and controller states.
// ----------------------------------------------------------------------------
package dqd_pkg;

  // operation codes carried in the request kind field
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_BACK   = 3'd2;
  localparam logic [2:0] KIND_DEL_FIRST  = 3'd3;
  localparam logic [2:0] KIND_DEL_ALL    = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef logic signed [31:0] value_t;

  typedef struct packed {
    logic [2:0] kind;
    value_t     value;
  } in_t;

  typedef struct packed {
    value_t     popped;
    logic [1:0] status;
    logic [4:0] removed_count;
    logic [4:0] occupancy;
  } out_t;

  // per-cycle command broadcast to every cell
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_SHR,
    CMD_PUT,
    CMD_SCAN
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      put;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

endpackage

FILE: hdl/dqd_cell.sv
// ----------------------------------------------------------------------------
// dqd_cell: one storage cell of the deque chain
// Holds one entry and moves it to or from its neighbors as the broadcast
// command says.
// ----------------------------------------------------------------------------
module dqd_cell import dqd_pkg::*; #(
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] tgt,
  input  logic [IDX_W-1:0] my_idx,
  input  value_t           din,
  input  value_t           left_val,
  input  value_t           right_val,
  output value_t           val_o
);

  value_t val_r;
  value_t val_nxt;
  logic   hit;

  assign hit = (my_idx == tgt);

  // next entry value
  always_comb begin
    val_nxt = val_r;
    unique case (ctl.cmd)
      CMD_HOLD: val_nxt = val_r;
      CMD_SHR:  val_nxt = left_val;
      CMD_PUT:  if (hit) begin
        val_nxt = din;
      end
      CMD_SCAN: begin
        if (hit && ctl.put) begin
          val_nxt = din;
        end else begin
          val_nxt = right_val;
        end
      end
      default:  val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_o = val_r;

endmodule

FILE: hdl/dqd_ctrl.sv
// ----------------------------------------------------------------------------
// dqd_ctrl: deque controller
// Decodes requests, sequences the rotate-and-filter scan for pops and
// deletes, keeps the fill count and holds the result register.
// ----------------------------------------------------------------------------
module dqd_ctrl import dqd_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  in_t                          in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output out_t                         out_data,
  input  value_t                       head,
  output cell_ctl_t                    cell_ctl,
  output logic [$clog2(CAPACITY)-1:0]  cell_tgt,
  output value_t                       cell_din
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] m_r, m_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] removed_r, removed_nxt;
  value_t           popped_r, popped_nxt;
  logic             found_r, found_nxt;
  logic [2:0]       op_r, op_nxt;
  value_t           val_r, val_nxt;
  out_t             res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  logic             slot_free;
  logic             scan_op;
  logic             last_step;
  logic             is_full;
  logic             del;
  logic             load_out;
  out_t             load_data;
  out_t             imm_res;
  logic [CNT_W-1:0] m_dec;
  logic [CNT_W-1:0] n_dec;

  // low five bits of a count, zero-extended when the count is narrower
  function automatic logic [4:0] to5(input logic [CNT_W-1:0] c);
    logic [CNT_W+4:0] e;
    e = {5'b0, c};
    return e[4:0];
  endfunction

  assign slot_free = !out_valid_r || !out_stall;
  assign is_full   = (fill_r == CAP_CNT);
  assign scan_op   = ((in_data.kind == KIND_POP_BACK) || (in_data.kind == KIND_DEL_FIRST) ||
                      (in_data.kind == KIND_DEL_ALL)) && (fill_r != '0);
  assign n_dec     = n_r - 1'b1;
  assign m_dec     = m_r - 1'b1;
  assign last_step = (k_r == n_dec);

  // head dropped on a match (delete first: first only), or on a pop when it is the back
  assign del = ((op_r == KIND_DEL_ALL) && (head == val_r)) ||
               ((op_r == KIND_DEL_FIRST) && (head == val_r) && !found_r) ||
               ((op_r == KIND_POP_BACK) && last_step);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) begin
        if (scan_op) begin
          state_nxt = ST_SCAN;
        end else if (!slot_free) begin
          state_nxt = ST_RESP;
        end
      end
      ST_SCAN: if (last_step) begin
        state_nxt = ST_RESP;
      end
      ST_RESP: if (slot_free) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath control and result build
  always_comb begin
    cell_ctl    = '{cmd: CMD_HOLD, put: 1'b0};
    cell_tgt    = '0;
    cell_din    = in_data.value;
    fill_nxt    = fill_r;
    n_nxt       = n_r;
    m_nxt       = m_r;
    k_nxt       = k_r;
    removed_nxt = removed_r;
    popped_nxt  = popped_r;
    found_nxt   = found_r;
    op_nxt      = op_r;
    val_nxt     = val_r;
    res_nxt     = res_r;
    load_out    = 1'b0;
    load_data   = res_r;
    imm_res     = '{popped: '0, status: STAT_OK, removed_count: '0, occupancy: '0};
    unique case (state_r)
      ST_IDLE: if (in_valid) begin
        op_nxt      = in_data.kind;
        val_nxt     = in_data.value;
        n_nxt       = fill_r;
        m_nxt       = fill_r;
        k_nxt       = '0;
        removed_nxt = '0;
        popped_nxt  = '0;
        found_nxt   = 1'b0;
        unique case (in_data.kind) inside
          KIND_PUSH_FRONT: begin
            if (is_full) begin
              imm_res.status = STAT_FULL;
            end else begin
              cell_ctl = '{cmd: CMD_SHR, put: 1'b1};
              fill_nxt = fill_r + 1'b1;
            end
          end
          KIND_PUSH_BACK: begin
            if (is_full) begin
              imm_res.status = STAT_FULL;
            end else begin
              cell_ctl = '{cmd: CMD_PUT, put: 1'b1};
              cell_tgt = fill_r[IDX_W-1:0];
              fill_nxt = fill_r + 1'b1;
            end
          end
          KIND_POP_BACK, KIND_DEL_FIRST, KIND_DEL_ALL: begin
            if (fill_r == '0) begin
              imm_res.status = STAT_EMPTY;
            end
          end
          default: ;
        endcase
        imm_res.occupancy = to5(fill_nxt);
        if (!scan_op) begin
          res_nxt   = imm_res;
          load_out  = slot_free;
          load_data = imm_res;
        end
      end
      ST_SCAN: begin
        // rotate left by one; the front entry goes back in at the live tail unless dropped
        cell_ctl = '{cmd: CMD_SCAN, put: !del};
        cell_tgt = m_dec[IDX_W-1:0];
        cell_din = head;
        k_nxt    = k_r + 1'b1;
        if (del) begin
          m_nxt       = m_dec;
          removed_nxt = removed_r + 1'b1;
          found_nxt   = 1'b1;
          if (op_r == KIND_POP_BACK) begin
            popped_nxt = head;
          end
        end
        if (last_step) begin
          fill_nxt = m_nxt;
          res_nxt  = '{popped: popped_nxt, status: STAT_OK,
                       removed_count: to5(removed_nxt), occupancy: to5(m_nxt)};
        end
      end
      ST_RESP: begin
        load_out  = slot_free;
        load_data = res_r;
      end
      default: ;
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = load_data;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    m_r        <= m_nxt;
    k_r        <= k_nxt;
    removed_r  <= removed_nxt;
    popped_r   <= popped_nxt;
    found_r    <= found_nxt;
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // fill count stays within capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CAP_CNT)
    else $error("fill count above capacity");

  // live count never drops below the entries still to be scanned
  a_live_cover: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (({1'b0, m_r} + {1'b0, k_r}) >= {1'b0, n_r}) && (m_r != '0))
    else $error("scan lost track of live entries");

  // pop and delete-first remove at most one entry
  a_single_remove: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && ((op_r == KIND_POP_BACK) || (op_r == KIND_DEL_FIRST)))
      |-> (removed_r <= CNT_W'(1)))
    else $error("more than one entry removed");

  // after a scan, kept plus removed equals what was held
  a_scan_balance: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RESP) && ($past(state_r) == ST_SCAN)) |-> ((fill_r + removed_r) == n_r))
    else $error("scan count mismatch");
`endif

endmodule

FILE: hdl/deque_with_delete_by_value_core.sv
// ----------------------------------------------------------------------------
// deque_with_delete_by_value_core: bounded deque with delete by value
// Ordered store of signed 32-bit values held in a chain of cells, front at
// cell zero, with push front/back, pop back, delete first and delete all.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one request per accept (in_valid high, in_stall low) with an
//                 operation kind and a value; in_stall is high while the block
//                 is busy with a request.
//   out channel : exactly one result per request, in request order, held in
//                 an output register until taken (out_valid high, out_stall low).
// Latency and throughput:
//   pushes, unused kinds and pops or deletes on an empty store finish in the
//   accept cycle: one request per cycle while the output register drains.
//   pop back, delete first and delete all rotate the held entries once through
//   cell zero, one entry per cycle at a pace set by the single compare at the
//   front of the chain; the accept is followed by one scan step per entry held
//   and a hand-over of the result to the output register.
// Stall: a request finished while the previous result still waits is parked
//   and in_stall stays high until the output register frees up.
// Reset: rst_n low empties the store and drops any pending result; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module deque_with_delete_by_value_core import dqd_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int IDX_W = $clog2(CAPACITY);

  cell_ctl_t        cell_ctl;
  logic [IDX_W-1:0] cell_tgt;
  value_t           cell_din;
  value_t           cell_val [CAPACITY];

  // controller
  dqd_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .head      (cell_val[0]),
    .cell_ctl  (cell_ctl),
    .cell_tgt  (cell_tgt),
    .cell_din  (cell_din)
  );

  // chain of cells, front at index zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    value_t left_v;
    value_t right_v;

    if (i == 0) begin : g_first
      assign left_v = cell_din;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_din;
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end

    dqd_cell #(
      .IDX_W (IDX_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .tgt       (cell_tgt),
      .my_idx    (IDX_W'(i)),
      .din       (cell_din),
      .left_val  (left_v),
      .right_val (right_v),
      .val_o     (cell_val[i])
    );
  end

endmodule

FILE: sim/deque_with_delete_by_value_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_delete_by_value_core_test: request/result check of the deque
// Sends push, pop and delete-by-value requests over the valid/stall channel,
// keeps its own copy of the ordered store to work out every result, and
// compares each result field by field in request order. Both sides idle and
// stall at random; one phase holds the result side off for a long stretch.
// ----------------------------------------------------------------------------
module deque_with_delete_by_value_core_test;
  import dqd_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 40;

  // kind codes the block ignores
  localparam logic [2:0] KIND_SPARE_5 = 3'd5;
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;

  typedef struct {
    in_t         req;
    int unsigned gap;
    bit          drain;
  } req_slot_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // values reused often so that deletes find matches
  value_t match_pool [6] = '{32'sd0, 32'sd1, -32'sd1, 32'sh7fffffff, 32'sh80000000, 32'sd42};

  req_slot_t req_backlog[$];
  out_t      outstanding_results[$];
  value_t    held_vals[$];

  logic req_taken = 1'b0;
  logic res_taken = 1'b0;
  bit   rx_idle_on = 1'b0;
  int   rx_wait = 0;
  int   long_hold_ticket = 0;
  int   long_hold_seen = 0;

  int   mismatch_count = 0;
  int   reqs_sent = 0;
  int   results_seen = 0;
  int   full_hits = 0;
  int   empty_hits = 0;
  int   multi_removes = 0;
  int   watch_cycles;

  deque_with_delete_by_value_core #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one request to the local copy of the store and build its result
  task automatic deque_apply(input in_t r, output out_t res);
    value_t kept[$];
    int     n;
    res = '0;
    res.status = STAT_OK;
    n = 0;
    case (r.kind) inside
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (held_vals.size() >= CAPACITY) res.status = STAT_FULL;
        else if (r.kind == KIND_PUSH_FRONT) held_vals.push_front(r.value);
        else held_vals.push_back(r.value);
      end
      KIND_POP_BACK: begin
        if (held_vals.size() == 0) res.status = STAT_EMPTY;
        else begin
          res.popped = held_vals.pop_back();
          n = 1;
        end
      end
      KIND_DEL_FIRST: begin
        if (held_vals.size() == 0) res.status = STAT_EMPTY;
        else begin
          for (int i = 0; i < held_vals.size(); i++) begin
            if (held_vals[i] == r.value) begin
              held_vals.delete(i);
              n = 1;
              break;
            end
          end
        end
      end
      KIND_DEL_ALL: begin
        if (held_vals.size() == 0) res.status = STAT_EMPTY;
        else begin
          foreach (held_vals[i]) begin
            if (held_vals[i] == r.value) n++;
            else kept.push_back(held_vals[i]);
          end
          held_vals = kept;
        end
      end
      default: ;
    endcase
    res.removed_count = 5'(n);
    res.occupancy     = 5'(held_vals.size());
    if (res.status == STAT_FULL) full_hits++;
    if (res.status == STAT_EMPTY) empty_hits++;
    if (n > 1) multi_removes++;
  endtask

  task automatic queue_req(input logic [2:0] kind, input value_t value,
                           input int unsigned gap, input bit drain);
    req_slot_t s;
    s.req.kind  = kind;
    s.req.value = value;
    s.gap       = gap;
    s.drain     = drain;
    req_backlog.push_back(s);
  endtask

  // random requests; grow_pct sets how often a push is picked
  task automatic queue_random(input int count, input int grow_pct, input bit send_idle);
    logic [2:0]  kind;
    value_t      value;
    int unsigned r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) kind = 3'($urandom_range(KIND_SPARE_5, KIND_SPARE_7));
      else if (r < 3 + grow_pct) kind = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
      else begin
        r = $urandom_range(0, 9);
        kind = (r < 4) ? KIND_POP_BACK : (r < 7) ? KIND_DEL_FIRST : KIND_DEL_ALL;
      end
      if ($urandom_range(0, 3) != 0) value = match_pool[$urandom_range(0, 5)];
      else value = $urandom;
      queue_req(kind, value, send_idle ? $urandom_range(0, 13) : 0, $urandom_range(0, 99) == 0);
    end
  endtask

  task automatic wait_sent();
    while (req_backlog.size() != 0 || in_valid) @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst_n) begin : drive_req
      logic      offer;
      req_slot_t s;
      offer = in_valid && !req_taken;
      if (!offer && req_backlog.size() != 0) begin
        if (req_backlog[0].gap != 0) req_backlog[0].gap--;
        else if (!req_backlog[0].drain || outstanding_results.size() == 0) begin
          s = req_backlog.pop_front();
          in_data <= s.req;
          offer = 1'b1;
        end
      end
      in_valid <= offer;
    end
  end

  // result side stall
  always @(negedge clk) begin
    if (rst_n) begin
      if (long_hold_ticket != long_hold_seen) begin
        long_hold_seen = long_hold_ticket;
        rx_wait = LONG_HOLD;
      end else if (res_taken) begin
        rx_wait = rx_idle_on ? $urandom_range(0, 13) : 0;
      end
      if (rx_wait != 0) begin
        out_stall <= 1'b1;
        rx_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: check results, then record accepted requests
  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken <= 1'b0;
      res_taken <= 1'b0;
    end else begin : watch
      out_t want;
      out_t fresh;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (outstanding_results.size() == 0) begin
          $error("result with no request waiting: %h", out_data);
          mismatch_count++;
        end else begin
          want = outstanding_results.pop_front();
          if (out_data.popped !== want.popped) begin
            $error("popped: expected %0d, got %0d", want.popped, out_data.popped);
            mismatch_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            mismatch_count++;
          end
          if (out_data.removed_count !== want.removed_count) begin
            $error("removed_count: expected %0d, got %0d", want.removed_count,
                   out_data.removed_count);
            mismatch_count++;
          end
          if (out_data.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, out_data.occupancy);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        deque_apply(in_data, fresh);
        outstanding_results.push_back(fresh);
        reqs_sent++;
      end
      req_taken <= in_valid && !in_stall;
      res_taken <= out_valid && !out_stall;
    end
  end

  // timeout
  initial begin
    for (watch_cycles = 0; watch_cycles < CYCLE_LIMIT; watch_cycles++) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty store, spare kinds, fill up, full, deletes
    queue_req(KIND_POP_BACK, 32'sd0, 0, 1'b0);
    queue_req(KIND_DEL_FIRST, 32'sd5, 0, 1'b0);
    queue_req(KIND_DEL_ALL, 32'sd5, 0, 1'b0);
    queue_req(KIND_SPARE_5, -32'sd1, 0, 1'b0);
    queue_req(KIND_SPARE_6, 32'sh7fffffff, 0, 1'b0);
    queue_req(KIND_SPARE_7, 32'sh80000000, 0, 1'b0);
    for (int i = 0; i < CAPACITY; i++)
      queue_req((i % 2) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, match_pool[i % 6], 0, 1'b0);
    queue_req(KIND_PUSH_FRONT, 32'sd1, 0, 1'b0);
    queue_req(KIND_PUSH_BACK, 32'sd1, 0, 1'b0);
    queue_req(KIND_DEL_FIRST, 32'sd12345, 0, 1'b0);
    queue_req(KIND_DEL_FIRST, 32'sd42, 0, 1'b0);
    queue_req(KIND_DEL_ALL, -32'sd1, 0, 1'b0);
    queue_req(KIND_POP_BACK, 32'sd0, 0, 1'b0);
    wait_sent();

    // balanced mix, both sides idling
    rx_idle_on = 1'b1;
    queue_random(400, 45, 1'b1);
    wait_sent();

    // back to back with no idling
    rx_idle_on = 1'b0;
    queue_random(300, 50, 1'b0);
    wait_sent();

    // result side held off while requests keep coming
    long_hold_ticket++;
    queue_random(60, 50, 1'b0);
    wait_sent();

    // sender waits for every result before this one
    queue_req(KIND_POP_BACK, 32'sd0, 0, 1'b1);
    wait_sent();

    // grow toward full, then shrink toward empty
    rx_idle_on = 1'b1;
    queue_random(400, 70, 1'b1);
    wait_sent();
    queue_random(400, 25, 1'b1);
    wait_sent();

    // mixed tail with idling on the result side only
    queue_random(300, 48, 1'b0);
    wait_sent();

    while (outstanding_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (outstanding_results.size() != 0) begin
      $error("%0d results never arrived", outstanding_results.size());
      mismatch_count++;
    end

    $display("covered %0d requests and %0d results over %0d cycles",
             reqs_sent, results_seen, watch_cycles);
    $display("full pushes %0d, empty pops/deletes %0d, multi-match deletes %0d",
             full_hits, empty_hits, multi_removes);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
